>>> hdl/xte_pkg.sv
// ----------------------------------------------------------------------------
// xte_pkg: shared types and constants for the XML text escaper
// Command codes passed from the classifier to the expander, plus the
// entity spelling tables.
// ----------------------------------------------------------------------------
package xte_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  // Index into an entity spelling; longest spelling is seven bytes
  localparam int unsigned IDX_W = 3;

  typedef enum logic [2:0] {
    CMD_PASS,
    CMD_AMP,
    CMD_LT,
    CMD_QUOTE,
    CMD_GT,
    CMD_FAIL
  } xte_kind_t;

  typedef struct packed {
    xte_kind_t  kind;
    logic [7:0] data;
  } xte_cmd_t;

  // Number of output bytes a command expands to
  function automatic logic [IDX_W-1:0] ent_len(input xte_kind_t kind);
    logic [IDX_W-1:0] len;
    unique case (kind)
      CMD_AMP:   len = IDX_W'(5);
      CMD_LT:    len = IDX_W'(4);
      CMD_GT:    len = IDX_W'(4);
      CMD_QUOTE: len = IDX_W'(7);
      default:   len = IDX_W'(1);
    endcase
    return len;
  endfunction

  // Output byte at position idx of a command's expansion
  function automatic logic [7:0] ent_char(input xte_kind_t kind,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [7:0] data);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (kind)
      CMD_PASS: ch = data;
      CMD_FAIL: ch = CH_NUL;
      CMD_AMP: begin
        unique case (idx)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = 8'h61;  // a
          3'd2:    ch = 8'h6D;  // m
          3'd3:    ch = 8'h70;  // p
          default: ch = CH_SEMI;
        endcase
      end
      CMD_LT: begin
        unique case (idx)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = 8'h6C;  // l
          3'd2:    ch = 8'h74;  // t
          default: ch = CH_SEMI;
        endcase
      end
      CMD_GT: begin
        unique case (idx)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = 8'h67;  // g
          3'd2:    ch = 8'h74;  // t
          default: ch = CH_SEMI;
        endcase
      end
      CMD_QUOTE: begin
        unique case (idx)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = 8'h71;  // q
          3'd2:    ch = 8'h75;  // u
          3'd3:    ch = 8'h6F;  // o
          3'd4:    ch = 8'h74;  // t
          3'd5:    ch = 8'h65;  // e
          default: ch = CH_SEMI;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/xte_in_if.sv
// ----------------------------------------------------------------------------
// xte_in_if: input byte channel
// Valid/ready channel carrying one text byte and its mode flag per item.
// ----------------------------------------------------------------------------
interface xte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       content_mode;

  modport source (output valid, output text_byte, output content_mode, input ready);
  modport sink   (input valid, input text_byte, input content_mode, output ready);
endinterface

>>> hdl/xte_out_if.sv
// ----------------------------------------------------------------------------
// xte_out_if: escaped output channel
// Valid/ready channel carrying one escaped byte and its flags per item.
// ----------------------------------------------------------------------------
interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       failed;

  modport source (output valid, output out_byte, output last_of_run, output failed,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input failed,
                  output ready);
endinterface

>>> hdl/xml_text_escaper.sv
// ----------------------------------------------------------------------------
// xml_text_escaper: XML text escaping engine
// Escapes a byte stream for element content or attribute values, expanding
// special characters into entities and flagging forbidden control bytes.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                           item
//  in_chan   in   text_byte[7:0], content_mode      one source byte
//  out_chan  out  out_byte[7:0], last_of_run, failed one escaped byte
//
// Expansion: an ordinary byte gives one output byte in the expander; an entity
// gives one output byte per byte of its spelling (4 for &lt; and &gt;, 5 for &amp;, 7 for
// &quote;). The expander's single output byte per cycle, unless out_chan stalls, sets the rate.
// The classifier accepts one byte per cycle while the command queue
// (QUEUE_DEPTH entries) has room; end-of-string bytes and bytes after a
// failure are absorbed without entering the queue.
// Reset: synchronous, active low; clears bracket history, failure, queue
// and output stage.
// Stalls: out_chan.ready low holds the output stage; the queue then fills
// and in_chan.ready falls.
// ----------------------------------------------------------------------------
module xml_text_escaper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  xte_in_if.sink    in_chan,
  xte_out_if.source out_chan
);

  logic              push;
  logic              push_ready;
  logic              pop;
  logic              head_valid;
  xte_pkg::xte_cmd_t push_cmd;
  xte_pkg::xte_cmd_t head_cmd;

  // Classify incoming bytes
  xte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_push  (push),
    .q_cmd   (push_cmd),
    .q_ready (push_ready)
  );

  // Decouple classifier from expander
  xte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Expand commands into output bytes
  xte_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (head_valid),
    .q_cmd    (head_cmd),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

endmodule

>>> hdl/xte_front.sv
// ----------------------------------------------------------------------------
// xte_front: input classifier
// Accepts text bytes, tracks the bracket history and sticky failure, and
// pushes one command per byte that produces output.
// ----------------------------------------------------------------------------
module xte_front (
  input  logic             clk,
  input  logic             rst_n,
  xte_in_if.sink           in_chan,
  output logic             q_push,
  output xte_pkg::xte_cmd_t q_cmd,
  input  logic             q_ready
);

  logic       prev_r, prev_nxt;
  logic       prev2_r, prev2_nxt;
  logic       fail_r, fail_nxt;
  logic       accept;
  logic       forbidden;
  logic [7:0] b;

  assign b         = in_chan.text_byte;
  assign in_chan.ready = q_ready;
  assign accept    = in_chan.valid && q_ready;

  // Flag control bytes other than NUL, tab, line feed and carriage return
  assign forbidden = (b != xte_pkg::CH_NUL) && (b < xte_pkg::CH_SPACE) &&
                     (b != xte_pkg::CH_TAB) && (b != xte_pkg::CH_LF) &&
                     (b != xte_pkg::CH_CR);

  // Classify the byte into a command
  always_comb begin
    q_cmd.data = b;
    priority if (forbidden)
      q_cmd.kind = xte_pkg::CMD_FAIL;
    else if (b == xte_pkg::CH_AMP)
      q_cmd.kind = xte_pkg::CMD_AMP;
    else if (b == xte_pkg::CH_LT)
      q_cmd.kind = xte_pkg::CMD_LT;
    else if (b == xte_pkg::CH_QUOTE && !in_chan.content_mode)
      q_cmd.kind = xte_pkg::CMD_QUOTE;
    else if (b == xte_pkg::CH_GT && in_chan.content_mode && prev_r && prev2_r)
      q_cmd.kind = xte_pkg::CMD_GT;
    else
      q_cmd.kind = xte_pkg::CMD_PASS;
  end

  // Drop end-of-string bytes and everything after a failure
  assign q_push = accept && !fail_r && (b != xte_pkg::CH_NUL);

  // Advance bracket history and failure state
  always_comb begin
    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    fail_nxt  = fail_r;
    if (accept && !fail_r) begin
      if (b == xte_pkg::CH_NUL) begin
        prev_nxt  = 1'b0;
        prev2_nxt = 1'b0;
      end else if (forbidden) begin
        fail_nxt = 1'b1;
      end else begin
        prev2_nxt = prev_r;
        prev_nxt  = (b == xte_pkg::CH_RBRACK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      prev2_r <= 1'b0;
      fail_r  <= 1'b0;
    end else begin
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // Failure stays set until reset
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |=> fail_r)
    else $error("failure flag cleared without reset");

endmodule

>>> hdl/xte_fifo.sv
// ----------------------------------------------------------------------------
// xte_fifo: command queue
// Small register queue between classifier and expander; head is read
// combinationally.
// ----------------------------------------------------------------------------
module xte_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xte_pkg::xte_cmd_t push_cmd,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output xte_pkg::xte_cmd_t head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  xte_pkg::xte_cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  // Occupancy never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue occupancy overflow");

endmodule

>>> hdl/xte_back.sv
// ----------------------------------------------------------------------------
// xte_back: entity expander
// Walks the head command one output byte per cycle, unless out_chan stalls, into a
// registered output stage and pops it after its last byte.
// ----------------------------------------------------------------------------
module xte_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  xte_pkg::xte_cmd_t q_cmd,
  output logic              q_pop,
  xte_out_if.source         out_chan
);

  logic [xte_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      valid_r, valid_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      last_r, last_nxt;
  logic                      failed_r, failed_nxt;
  logic                      load;
  logic                      at_end;

  assign load   = q_valid && (!valid_r || out_chan.ready);
  assign at_end = (idx_r == xte_pkg::ent_len(q_cmd.kind) - xte_pkg::IDX_W'(1));
  assign q_pop  = load && at_end;

  // Load the next expansion byte or drain the output stage
  always_comb begin
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    failed_nxt = failed_r;
    if (load) begin
      valid_nxt  = 1'b1;
      byte_nxt   = xte_pkg::ent_char(q_cmd.kind, idx_r, q_cmd.data);
      last_nxt   = at_end;
      failed_nxt = (q_cmd.kind == xte_pkg::CMD_FAIL);
      idx_nxt    = at_end ? '0 : idx_r + xte_pkg::IDX_W'(1);
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    failed_r <= failed_nxt;
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.out_byte    = byte_r;
  assign out_chan.last_of_run = last_r;
  assign out_chan.failed      = failed_r;

  // A partly expanded command stays at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> q_valid)
    else $error("queue head lost mid-expansion");

  // A failure report is always a single-byte run
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && failed_r) |-> last_r)
    else $error("failure report not marked last");

endmodule

>>> test/xml_text_escaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_text_escaper_tb: self-checking bench for the XML text escaper
// Feeds text bytes in both modes through the valid/ready input channel and
// checks every escaped byte against a predictor of the entity expansion,
// the "]]>" history and the sticky failure. A directed table comes first,
// then random strings with random stalls on both sides, then a forbidden
// byte and the bytes that must be dropped after it.
// ----------------------------------------------------------------------------
module xml_text_escaper_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_ITEMS   = 90;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned DIR_ROWS     = 26;

  // One escaped output byte
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       failed;
  } esc_byte_t;

  // One row of the directed table; typed rows pass through unchanged
  typedef struct {
    logic [7:0] text_byte;
    logic       content;
    bit         typed;
  } text_row_t;

  logic clk;
  logic rst_n;

  xte_in_if  in_chan ();
  xte_out_if out_chan ();

  xml_text_escaper i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state
  bit bracket_1;
  bit bracket_2;
  bit fail_latched;

  esc_byte_t   pending_out[$];
  int unsigned mismatches;
  int unsigned bytes_checked;
  int unsigned bytes_sent;
  int unsigned entity_count;
  int unsigned gt_count;
  int unsigned string_count;
  bit          calm;

  text_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{8'h41,              1'b0, 1'b1},
    '{xte_pkg::CH_SPACE,  1'b0, 1'b1},
    '{8'hFF,              1'b1, 1'b1},
    '{8'h80,              1'b0, 1'b1},
    '{8'h7F,              1'b1, 1'b1},
    '{xte_pkg::CH_TAB,    1'b0, 1'b1},
    '{xte_pkg::CH_LF,     1'b1, 1'b1},
    '{xte_pkg::CH_CR,     1'b0, 1'b1},
    '{xte_pkg::CH_AMP,    1'b0, 1'b0},
    '{xte_pkg::CH_AMP,    1'b1, 1'b0},
    '{xte_pkg::CH_LT,     1'b0, 1'b0},
    '{xte_pkg::CH_LT,     1'b1, 1'b0},
    '{xte_pkg::CH_QUOTE,  1'b0, 1'b0},
    '{xte_pkg::CH_QUOTE,  1'b1, 1'b1},
    '{xte_pkg::CH_GT,     1'b0, 1'b1},
    '{xte_pkg::CH_RBRACK, 1'b1, 1'b1},
    '{xte_pkg::CH_RBRACK, 1'b1, 1'b1},
    '{xte_pkg::CH_GT,     1'b1, 1'b0},
    '{xte_pkg::CH_RBRACK, 1'b1, 1'b1},
    '{xte_pkg::CH_RBRACK, 1'b1, 1'b1},
    '{xte_pkg::CH_NUL,    1'b1, 1'b0},
    '{xte_pkg::CH_GT,     1'b1, 1'b1},
    '{xte_pkg::CH_RBRACK, 1'b0, 1'b1},
    '{xte_pkg::CH_RBRACK, 1'b1, 1'b1},
    '{xte_pkg::CH_GT,     1'b1, 1'b0},
    '{xte_pkg::CH_NUL,    1'b0, 1'b0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the escaped bytes for one accepted text byte
  function automatic void escape_byte(input logic [7:0] b, input logic in_content,
                                      output esc_byte_t res[$]);
    string ent;
    ent = "";
    res = {};
    if (fail_latched) return;
    if (b == xte_pkg::CH_NUL) begin
      bracket_1 = 1'b0;
      bracket_2 = 1'b0;
      string_count++;
      return;
    end
    if (b < xte_pkg::CH_SPACE && b != xte_pkg::CH_TAB && b != xte_pkg::CH_LF &&
        b != xte_pkg::CH_CR) begin
      fail_latched = 1'b1;
      res.insert(res.size(), esc_byte_t'{xte_pkg::CH_NUL, 1'b1, 1'b1});
      return;
    end
    if (b == xte_pkg::CH_AMP) begin
      ent = "&amp;";
    end else if (b == xte_pkg::CH_LT) begin
      ent = "&lt;";
    end else if (b == xte_pkg::CH_QUOTE && !in_content) begin
      ent = "&quote;";
    end else if (b == xte_pkg::CH_GT && in_content && bracket_1 && bracket_2) begin
      ent = "&gt;";
      gt_count++;
    end
    if (ent.len() == 0) begin
      res.insert(res.size(), esc_byte_t'{b, 1'b1, 1'b0});
    end else begin
      entity_count++;
      for (int k = 0; k < ent.len(); k++) begin
        res.insert(res.size(), esc_byte_t'{ent[k], k == ent.len() - 1, 1'b0});
      end
    end
    bracket_2 = bracket_1;
    bracket_1 = (b == xte_pkg::CH_RBRACK);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Hold the byte on the channel until it is taken, then record what it causes.
  // A typed item expects its byte back unchanged as a single result.
  task automatic send_text(input logic [7:0] b, input logic in_content,
                           input bit typed = 1'b0);
    esc_byte_t res[$];
    in_chan.valid        <= 1'b1;
    in_chan.text_byte    <= b;
    in_chan.content_mode <= in_content;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    escape_byte(b, in_content, res);
    if (typed) begin
      pending_out.insert(pending_out.size(), esc_byte_t'{b, 1'b1, 1'b0});
    end else begin
      foreach (res[k]) pending_out.insert(pending_out.size(), res[k]);
    end
  endtask

  // Drop valid for a random burst
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Pick a text byte, weighted toward brackets and the escaped characters
  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: b = xte_pkg::CH_RBRACK;
      2:    b = xte_pkg::CH_GT;
      3: begin
        case ($urandom_range(0, 3))
          0:       b = xte_pkg::CH_AMP;
          1:       b = xte_pkg::CH_LT;
          2:       b = xte_pkg::CH_QUOTE;
          default: b = xte_pkg::CH_GT;
        endcase
      end
      4: begin
        case ($urandom_range(0, 2))
          0:       b = xte_pkg::CH_TAB;
          1:       b = xte_pkg::CH_LF;
          default: b = xte_pkg::CH_CR;
        endcase
      end
      default: b = 8'($urandom_range(32, 255));
    endcase
    return b;
  endfunction

  // Receiver: ready low in random bursts, none once the run is calm
  initial begin : out_stall
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Compare each accepted output byte with the oldest expectation
  always @(posedge clk) begin : check_out
    esc_byte_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_out.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h last=%0b failed=%0b",
                                out_chan.out_byte, out_chan.last_of_run,
                                out_chan.failed));
      end else begin
        want = pending_out.pop_front();
        bytes_checked++;
        if (out_chan.out_byte !== want.ch)
          flag_mismatch($sformatf("out_byte %02h, want %02h", out_chan.out_byte, want.ch));
        if (out_chan.last_of_run !== want.last)
          flag_mismatch($sformatf("last_of_run %0b, want %0b on byte %02h",
                                  out_chan.last_of_run, want.last, want.ch));
        if (out_chan.failed !== want.failed)
          flag_mismatch($sformatf("failed %0b, want %0b on byte %02h",
                                  out_chan.failed, want.failed, want.ch));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected",
             cycles, pending_out.size());
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [7:0]  b;
    logic        mode;
    int unsigned str_len;
    int unsigned rand_sent;
    bit          paused;

    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.text_byte    <= xte_pkg::CH_NUL;
    in_chan.content_mode <= 1'b0;
    calm         = 1'b0;
    paused       = 1'b0;
    rand_sent    = 0;
    bracket_1    = 1'b0;
    bracket_2    = 1'b0;
    fail_latched = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      maybe_idle();
      send_text(dir_rows[i].text_byte, dir_rows[i].content, dir_rows[i].typed);
    end

    // Random strings, most of them ended by a zero byte
    while (rand_sent < RAND_ITEMS) begin
      str_len = $urandom_range(1, 10);
      mode    = 1'($urandom_range(0, 1));
      for (int k = 0; k < str_len; k++) begin
        if ($urandom_range(0, 15) == 0) mode = ~mode;
        maybe_idle();
        send_text(pick_text(), mode);
        rand_sent++;
      end
      if ($urandom_range(0, 7) != 0) begin
        maybe_idle();
        send_text(xte_pkg::CH_NUL, 1'($urandom_range(0, 1)));
        rand_sent++;
      end
      // Hold the sender once until the block has caught up
      if (!paused && rand_sent >= RAND_ITEMS / 2) begin
        paused = 1'b1;
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0) @(posedge clk);
      end
      if (rand_sent >= (RAND_ITEMS * 3) / 4) calm = 1'b1;
    end

    // One forbidden byte, then everything after it must be dropped
    do b = 8'($urandom_range(1, 31));
    while (b == xte_pkg::CH_TAB || b == xte_pkg::CH_LF || b == xte_pkg::CH_CR);
    send_text(b, 1'($urandom_range(0, 1)));
    send_text(xte_pkg::CH_AMP, 1'b1);
    send_text(xte_pkg::CH_LT, 1'b0);
    send_text(xte_pkg::CH_QUOTE, 1'b0);
    send_text(8'h41, 1'b1);
    send_text(xte_pkg::CH_NUL, 1'b1);
    send_text(8'h01, 1'b0);
    send_text(8'hFF, 1'b1);
    in_chan.valid <= 1'b0;

    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d text bytes (%0d strings ended), checked %0d escaped bytes",
             bytes_sent, string_count, bytes_checked);
    $display("entities expanded %0d (%0d of them ]]> guards), sticky failure %0s",
             entity_count, gt_count, fail_latched ? "reached" : "not reached");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/xte_pkg.sv
hdl/xte_in_if.sv
hdl/xte_out_if.sv
hdl/xte_front.sv
hdl/xte_fifo.sv
hdl/xte_back.sv
hdl/xml_text_escaper.sv
test/xml_text_escaper_tb.sv
